@@ rtl/cau_pkg.sv @@
package cau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_MOD  = 3'd4,
        MODE_ARG  = 3'd5,
        MODE_CONJ = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    // quotient bits of the divider: |num| * 2^16 fits in 48 bits
    localparam int DIV_BITS  = 48;
    localparam int DIV_LAT   = DIV_BITS + 2;
    localparam int SQRT_BITS = 24;
    localparam int SQRT_LAT  = SQRT_BITS + 1;
    localparam int CORDIC_XW = 36;

    localparam logic signed [31:0] PI_Q16 = 32'sd205887;
    localparam logic signed [31:0] PI_Q24 = 32'sd52707179;

    typedef struct packed {
        logic [2:0]         mode;
        logic               den_zero;
        logic               sat;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_side;

    // atan(2^-idx) in units of 2^-24 rad
    function automatic logic signed [31:0] atan_q24(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd13176795;
            5'd1:  v = 32'sd7778716;
            5'd2:  v = 32'sd4110060;
            5'd3:  v = 32'sd2086331;
            5'd4:  v = 32'sd1047214;
            5'd5:  v = 32'sd524117;
            5'd6:  v = 32'sd262123;
            5'd7:  v = 32'sd131069;
            5'd8:  v = 32'sd65536;
            5'd9:  v = 32'sd32768;
            5'd10: v = 32'sd16384;
            5'd11: v = 32'sd8192;
            5'd12: v = 32'sd4096;
            5'd13: v = 32'sd2048;
            5'd14: v = 32'sd1024;
            5'd15: v = 32'sd512;
            5'd16: v = 32'sd256;
            5'd17: v = 32'sd128;
            5'd18: v = 32'sd64;
            5'd19: v = 32'sd32;
            5'd20: v = 32'sd16;
            5'd21: v = 32'sd8;
            5'd22: v = 32'sd4;
            5'd23: v = 32'sd2;
            5'd24: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/cau_div.sv @@
module cau_div (
    input  logic               i_clk,
    input  logic signed [32:0] i_num,
    input  logic        [31:0] i_den,
    output logic signed [31:0] o_quo,
    output logic               o_sat
);
    localparam int NB = cau_pkg::DIV_BITS;

    logic [NB-1:0] r_dvd [NB+1];
    logic [31:0]   r_rem [NB+1];
    logic [NB-1:0] r_quo [NB+1];
    logic [31:0]   r_den [NB+1];
    logic          r_neg [NB+1];

    logic [32:0]   w_mag;
    logic [32:0]   w_trial [NB];
    logic [32:0]   w_diff  [NB];
    logic          w_ge    [NB];
    logic [NB-1:0] w_q;
    logic          w_big;
    logic signed [31:0] n_quo;
    logic          n_sat;

    assign w_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            w_trial[k] = {r_rem[k], r_dvd[k][NB-1]};
            w_diff[k]  = w_trial[k] - {1'b0, r_den[k]};
            w_ge[k]    = (w_trial[k] >= {1'b0, r_den[k]});
        end
    end

    // one quotient bit per stage, restoring
    always_ff @(posedge i_clk) begin
        r_dvd[0] <= {w_mag[31:0], {(NB-32){1'b0}}};
        r_rem[0] <= '0;
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_num[32];
        for (int k = 0; k < NB; k++) begin
            r_rem[k+1] <= w_ge[k] ? w_diff[k][31:0] : w_trial[k][31:0];
            r_dvd[k+1] <= {r_dvd[k][NB-2:0], 1'b0};
            r_quo[k+1] <= {r_quo[k][NB-2:0], w_ge[k]};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    always_comb begin
        w_q   = r_quo[NB];
        w_big = |w_q[NB-1:32];
        if (r_neg[NB]) begin
            n_sat = w_big | (w_q[31] & (|w_q[30:0]));
            n_quo = n_sat ? 32'sh8000_0000 : $signed(32'(32'd0 - w_q[31:0]));
        end else begin
            n_sat = w_big | w_q[31];
            n_quo = n_sat ? 32'sh7fff_ffff : $signed(w_q[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_quo <= n_quo;
        o_sat <= n_sat;
    end

endmodule

@@ rtl/cau_cordic.sv @@
module cau_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic signed [15:0] i_re,
    input  logic signed [15:0] i_im,
    output logic signed [31:0] o_arg
);
    localparam int XW = cau_pkg::CORDIC_XW;

    logic signed [XW-1:0] r_x [STEPS+1];
    logic signed [XW-1:0] r_y [STEPS+1];
    logic signed [31:0]   r_z [STEPS+1];
    logic                 r_axis [STEPS+1];
    logic                 r_left [STEPS+1];

    logic signed [XW-1:0] w_x0, w_y0;
    logic signed [31:0]   w_z0;
    logic signed [XW-1:0] w_xn [STEPS];
    logic signed [XW-1:0] w_yn [STEPS];
    logic signed [31:0]   w_zn [STEPS];
    logic signed [31:0]   w_zr;
    logic signed [31:0]   n_arg;

    // fold the left half-plane onto the right one
    always_comb begin
        w_x0 = {{(XW-32){i_re[15]}}, i_re, 16'b0};
        w_y0 = {{(XW-32){i_im[15]}}, i_im, 16'b0};
        w_z0 = '0;
        if (i_re[15]) begin
            w_z0 = i_im[15] ? -cau_pkg::PI_Q24 : cau_pkg::PI_Q24;
            w_x0 = -w_x0;
            w_y0 = -w_y0;
        end
    end

    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            if (!r_y[i][XW-1]) begin
                w_xn[i] = r_x[i] + (r_y[i] >>> i);
                w_yn[i] = r_y[i] - (r_x[i] >>> i);
                w_zn[i] = r_z[i] + cau_pkg::atan_q24(5'(i));
            end else begin
                w_xn[i] = r_x[i] - (r_y[i] >>> i);
                w_yn[i] = r_y[i] + (r_x[i] >>> i);
                w_zn[i] = r_z[i] - cau_pkg::atan_q24(5'(i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= w_x0;
        r_y[0]    <= w_y0;
        r_z[0]    <= w_z0;
        r_axis[0] <= (i_im == 16'sd0);
        r_left[0] <= i_re[15];
        for (int i = 0; i < STEPS; i++) begin
            r_x[i+1]    <= w_xn[i];
            r_y[i+1]    <= w_yn[i];
            r_z[i+1]    <= w_zn[i];
            r_axis[i+1] <= r_axis[i];
            r_left[i+1] <= r_left[i];
        end
    end

    // round half up to Q15.16, clamp to +-pi; real axis is exact
    always_comb begin
        w_zr = (r_z[STEPS] + 32'sd128) >>> 8;
        if (r_axis[STEPS]) begin
            n_arg = r_left[STEPS] ? cau_pkg::PI_Q16 : 32'sd0;
        end else if (w_zr > cau_pkg::PI_Q16) begin
            n_arg = cau_pkg::PI_Q16;
        end else if (w_zr < -cau_pkg::PI_Q16) begin
            n_arg = -cau_pkg::PI_Q16;
        end else begin
            n_arg = w_zr;
        end
    end

    always_ff @(posedge i_clk) begin
        o_arg <= n_arg;
    end

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide, modulus, argument
// and conjugate on complex operands with signed Q7.8 parts; results in
// signed Q15.16 with a status code (ok, divide by zero, saturated).
//
// Input: drive i_mode and the four operand parts and raise start. The
// transaction is taken at every rising edge with start high and busy low.
// busy never rises: the datapath is a fixed-depth pipeline and takes a new
// transaction in every cycle.
// Output: o_strobe is high for exactly one cycle while o_res_re, o_res_im
// and o_status hold the result; results leave in the order taken.
// The depth from the accepting edge to o_strobe is the same for every
// opcode and every CORDIC_STEPS. It is set by the divider, which resolves
// one of its 48 quotient bits per stage; the square root (one root bit per
// stage) and the CORDIC (one rotation per stage) are padded to the same
// depth. Throughput is one transaction per cycle.
// Reset clears the valid bits of every stage, so no strobe follows reset
// until new transactions are taken. The receiver cannot stall the unit.
module complex_arithmetic_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [2:0]  i_mode,
    input  logic signed [15:0] i_a_re,
    input  logic signed [15:0] i_a_im,
    input  logic signed [15:0] i_b_re,
    input  logic signed [15:0] i_b_im,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic        [1:0]  o_status,
    output logic               o_strobe
);
    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int LAT   = cau_pkg::DIV_LAT;
    localparam int CPAD  = LAT - (STEPS + 2);
    localparam int SPAD  = LAT - cau_pkg::SQRT_LAT;
    localparam int SB    = cau_pkg::SQRT_BITS;
    localparam int SN    = 2 * SB;
    localparam int SR    = SB + 3;

    function automatic logic signed [31:0] f_scale(input logic signed [16:0] v);
        return {{7{v[16]}}, v, 8'b0};
    endfunction

    // ---- stage 0: operand capture
    logic               r_v0;
    logic        [2:0]  r_mode0;
    logic signed [15:0] r_ar0, r_ai0, r_br0, r_bi0;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode0 <= i_mode;
            r_ar0   <= i_a_re;
            r_ai0   <= i_a_im;
            r_br0   <= i_b_re;
            r_bi0   <= i_b_im;
        end
    end

    // ---- stage 1: products and the simple results
    logic               r_v1;
    logic        [2:0]  r_mode1;
    logic signed [15:0] r_ar1, r_ai1;
    logic signed [31:0] r_rr1, r_ii1, r_ri1, r_ir1;
    logic signed [31:0] r_sar1, r_sai1, r_sbr1, r_sbi1;
    logic signed [31:0] r_sre1, r_sim1;
    logic signed [31:0] n_sre1, n_sim1;
    logic signed [16:0] w_sum_re, w_sum_im, w_dif_re, w_dif_im, w_neg_im;

    assign w_sum_re = {r_ar0[15], r_ar0} + {r_br0[15], r_br0};
    assign w_sum_im = {r_ai0[15], r_ai0} + {r_bi0[15], r_bi0};
    assign w_dif_re = {r_ar0[15], r_ar0} - {r_br0[15], r_br0};
    assign w_dif_im = {r_ai0[15], r_ai0} - {r_bi0[15], r_bi0};
    assign w_neg_im = 17'sd0 - {r_ai0[15], r_ai0};

    always_comb begin
        case (cau_pkg::t_mode'(r_mode0))
            cau_pkg::MODE_ADD: begin
                n_sre1 = f_scale(w_sum_re);
                n_sim1 = f_scale(w_sum_im);
            end
            cau_pkg::MODE_SUB: begin
                n_sre1 = f_scale(w_dif_re);
                n_sim1 = f_scale(w_dif_im);
            end
            cau_pkg::MODE_CONJ: begin
                n_sre1 = f_scale({r_ar0[15], r_ar0});
                n_sim1 = f_scale(w_neg_im);
            end
            default: begin
                n_sre1 = '0;
                n_sim1 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= r_mode0;
        r_ar1   <= r_ar0;
        r_ai1   <= r_ai0;
        r_rr1   <= r_ar0 * r_br0;
        r_ii1   <= r_ai0 * r_bi0;
        r_ri1   <= r_ar0 * r_bi0;
        r_ir1   <= r_ai0 * r_br0;
        r_sar1  <= r_ar0 * r_ar0;
        r_sai1  <= r_ai0 * r_ai0;
        r_sbr1  <= r_br0 * r_br0;
        r_sbi1  <= r_bi0 * r_bi0;
        r_sre1  <= n_sre1;
        r_sim1  <= n_sim1;
    end

    // ---- stage 2: sums, product saturation, unit operands
    logic               r_v2;
    cau_pkg::t_side     r_side2, n_side2;
    logic signed [32:0] r_nre2, r_nim2;
    logic        [31:0] r_den2, r_msum2;
    logic signed [15:0] r_ar2, r_ai2;
    logic signed [32:0] w_mre, w_mim, w_nre, w_nim;
    logic        [31:0] w_den, w_msum;
    logic               w_msat_re, w_msat_im;
    logic signed [31:0] w_mre_s, w_mim_s;

    assign w_mre  = {r_rr1[31], r_rr1} - {r_ii1[31], r_ii1};
    assign w_mim  = {r_ri1[31], r_ri1} + {r_ir1[31], r_ir1};
    assign w_nre  = {r_rr1[31], r_rr1} + {r_ii1[31], r_ii1};
    assign w_nim  = {r_ir1[31], r_ir1} - {r_ri1[31], r_ri1};
    assign w_den  = $unsigned(r_sbr1) + $unsigned(r_sbi1);
    assign w_msum = $unsigned(r_sar1) + $unsigned(r_sai1);

    assign w_msat_re = w_mre[32] ^ w_mre[31];
    assign w_msat_im = w_mim[32] ^ w_mim[31];
    assign w_mre_s = w_msat_re ? (w_mre[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                               : w_mre[31:0];
    assign w_mim_s = w_msat_im ? (w_mim[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                               : w_mim[31:0];

    always_comb begin
        n_side2.mode     = r_mode1;
        n_side2.den_zero = (w_den == 32'd0);
        if (cau_pkg::t_mode'(r_mode1) == cau_pkg::MODE_MUL) begin
            n_side2.sat = w_msat_re | w_msat_im;
            n_side2.re  = w_mre_s;
            n_side2.im  = w_mim_s;
        end else begin
            n_side2.sat = 1'b0;
            n_side2.re  = r_sre1;
            n_side2.im  = r_sim1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2 <= n_side2;
        r_nre2  <= w_nre;
        r_nim2  <= w_nim;
        r_den2  <= w_den;
        r_msum2 <= w_msum;
        r_ar2   <= r_ar1;
        r_ai2   <= r_ai1;
    end

    // ---- sideband line alongside the long units
    cau_pkg::t_side r_sd [LAT];
    logic           r_vd [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else begin
            r_vd[0] <= r_v2;
            for (int k = 1; k < LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_side2;
        for (int k = 1; k < LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // ---- dividers: (a * conj(b)) * 2^16 / |b|^2
    logic signed [31:0] w_qre, w_qim;
    logic               w_qsat_re, w_qsat_im;

    cau_div u_div_re (
        .i_clk (i_clk),
        .i_num (r_nre2),
        .i_den (r_den2),
        .o_quo (w_qre),
        .o_sat (w_qsat_re)
    );

    cau_div u_div_im (
        .i_clk (i_clk),
        .i_num (r_nim2),
        .i_den (r_den2),
        .o_quo (w_qim),
        .o_sat (w_qsat_im)
    );

    // ---- square root, one root bit per stage
    logic [SN-1:0] r_sq_n    [SB+1];
    logic [SR-1:0] r_sq_rem  [SB+1];
    logic [SB-1:0] r_sq_root [SB+1];
    logic [SR-1:0] w_sq_sh    [SB];
    logic [SR-1:0] w_sq_trial [SB];
    logic          w_sq_ge    [SB];
    logic [SB-1:0] r_sqd [SPAD];

    always_comb begin
        for (int k = 0; k < SB; k++) begin
            w_sq_sh[k]    = {r_sq_rem[k][SB:0], r_sq_n[k][SN-1 -: 2]};
            w_sq_trial[k] = {1'b0, r_sq_root[k], 2'b01};
            w_sq_ge[k]    = (w_sq_sh[k] >= w_sq_trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_n[0]    <= {r_msum2, {(SN-32){1'b0}}};
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        for (int k = 0; k < SB; k++) begin
            r_sq_n[k+1]    <= {r_sq_n[k][SN-3:0], 2'b00};
            r_sq_rem[k+1]  <= w_sq_ge[k] ? (w_sq_sh[k] - w_sq_trial[k]) : w_sq_sh[k];
            r_sq_root[k+1] <= {r_sq_root[k][SB-2:0], w_sq_ge[k]};
        end
        r_sqd[0] <= r_sq_root[SB];
        for (int k = 1; k < SPAD; k++) begin
            r_sqd[k] <= r_sqd[k-1];
        end
    end

    // ---- argument
    logic signed [31:0] w_arg;
    logic signed [31:0] r_cd [CPAD];

    cau_cordic #(
        .STEPS (STEPS)
    ) u_cordic (
        .i_clk (i_clk),
        .i_re  (r_ar2),
        .i_im  (r_ai2),
        .o_arg (w_arg)
    );

    always_ff @(posedge i_clk) begin
        r_cd[0] <= w_arg;
        for (int k = 1; k < CPAD; k++) begin
            r_cd[k] <= r_cd[k-1];
        end
    end

    // ---- result select
    cau_pkg::t_side     w_sd;
    logic signed [31:0] n_res_re, n_res_im;
    cau_pkg::t_status   n_status;
    logic signed [31:0] r_res_re, r_res_im;
    cau_pkg::t_status   r_status;
    logic               r_strobe;

    assign w_sd = r_sd[LAT-1];

    always_comb begin
        n_res_re = '0;
        n_res_im = '0;
        n_status = cau_pkg::ST_OK;
        case (cau_pkg::t_mode'(w_sd.mode))
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_CONJ: begin
                n_res_re = w_sd.re;
                n_res_im = w_sd.im;
            end
            cau_pkg::MODE_MUL: begin
                n_res_re = w_sd.re;
                n_res_im = w_sd.im;
                n_status = w_sd.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            cau_pkg::MODE_DIV: begin
                if (w_sd.den_zero) begin
                    n_status = cau_pkg::ST_DIV0;
                end else begin
                    n_res_re = w_qre;
                    n_res_im = w_qim;
                    n_status = (w_qsat_re | w_qsat_im) ? cau_pkg::ST_SAT
                                                       : cau_pkg::ST_OK;
                end
            end
            cau_pkg::MODE_MOD: begin
                n_res_re = $signed({{(32-SB){1'b0}}, r_sqd[SPAD-1]});
            end
            cau_pkg::MODE_ARG: begin
                n_res_re = r_cd[CPAD-1];
            end
            default: begin
                n_res_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vd[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_status <= n_status;
    end

    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;
    assign o_strobe = r_strobe;

endmodule

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      CORDIC_STEPS = 16;
    localparam int      IDLE_LIMIT   = 2000;
    localparam int      TAIL_CYCLES  = 60;
    localparam longint  PI_RAD_Q16   = 205887;
    localparam longint  PI_RAD_Q24   = 52707179;
    localparam longint  ATAN_Q24 [0:31] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic        [1:0]  status;
    } t_cplx_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic        [2:0]  i_mode;
    logic signed [15:0] i_a_re;
    logic signed [15:0] i_a_im;
    logic signed [15:0] i_b_re;
    logic signed [15:0] i_b_im;
    logic signed [31:0] o_res_re;
    logic signed [31:0] o_res_im;
    logic        [1:0]  o_status;
    logic               o_strobe;

    t_cplx_res pending_results[$];
    int        mismatch_cnt;
    int        result_cnt;
    int        mode_cnt [0:7];
    int        quiet_cycles;
    bit        idle_on;

    complex_arithmetic_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_mode  (i_mode),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_res_re(o_res_re),
        .o_res_im(o_res_im),
        .o_status(o_status),
        .o_strobe(o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clamp32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint angle_q16(longint re, longint im);
        longint x, y, z, dx, dy;
        int     steps;
        steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
        if (im == 0) return (re < 0) ? PI_RAD_Q16 : 0;
        x = re * 65536;
        y = im * 65536;
        z = 0;
        // fold the left half-plane onto the right one
        if (x < 0) begin
            z = (y >= 0) ? PI_RAD_Q24 : -PI_RAD_Q24;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_Q24[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_Q24[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z > PI_RAD_Q16) z = PI_RAD_Q16;
        if (z < -PI_RAD_Q16) z = -PI_RAD_Q16;
        return z;
    endfunction

    function automatic t_cplx_res cplx_compute(logic [2:0] mode, longint ar, longint ai,
                                               longint br, longint bi);
        t_cplx_res r;
        longint    re, im, den;
        bit        sat;
        re = 0;
        im = 0;
        sat = 1'b0;
        r.status = cau_pkg::ST_OK;
        case (mode)
            cau_pkg::MODE_ADD: begin
                re = (ar + br) * 256; im = (ai + bi) * 256;
            end
            cau_pkg::MODE_SUB: begin
                re = (ar - br) * 256; im = (ai - bi) * 256;
            end
            cau_pkg::MODE_MUL: begin
                re = clamp32(ar * br - ai * bi, sat);
                im = clamp32(ar * bi + ai * br, sat);
            end
            cau_pkg::MODE_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = cau_pkg::ST_DIV0;
                end else begin
                    re = clamp32(((ar * br + ai * bi) * 65536) / den, sat);
                    im = clamp32(((ai * br - ar * bi) * 65536) / den, sat);
                end
            end
            cau_pkg::MODE_MOD:  re = root_floor((ar * ar + ai * ai) << 16);
            cau_pkg::MODE_ARG:  re = angle_q16(ar, ai);
            cau_pkg::MODE_CONJ: begin
                re = ar * 256; im = -ai * 256;
            end
            default: ;
        endcase
        if (sat) r.status = cau_pkg::ST_SAT;
        r.re = re[31:0];
        r.im = im[31:0];
        return r;
    endfunction

    // predict at the accepting edge from the values the unit sampled
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pending_results.push_back(cplx_compute(i_mode, i_a_re, i_a_im, i_b_re, i_b_im));
            mode_cnt[i_mode]++;
        end
    end

    always @(posedge i_clk) begin
        t_cplx_res exp_res;
        if (i_rst_n && o_strobe) begin
            result_cnt++;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result re=%0d im=%0d status=%0d",
                             o_res_re, o_res_im, o_status);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_res_re !== exp_res.re || o_res_im !== exp_res.im
                        || o_status !== exp_res.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                 exp_res.re, exp_res.im, exp_res.status,
                                 o_res_re, o_res_im, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(logic [2:0] mode, logic [15:0] ar, logic [15:0] ai,
                             logic [15:0] br, logic [15:0] bi);
        start  <= 1'b1;
        i_mode <= mode;
        i_a_re <= ar;
        i_a_im <= ai;
        i_b_re <= br;
        i_b_im <= bi;
        do @(posedge i_clk); while (busy);
        // hold off the next transaction in random bursts
        if (idle_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            5, 6: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_item(cau_pkg::MODE_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_item(cau_pkg::MODE_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_item(cau_pkg::MODE_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        send_item(cau_pkg::MODE_MUL, 16'h0100, 16'hff00, 16'h0200, 16'h0080);
        send_item(cau_pkg::MODE_DIV, 16'h0123, 16'h0456, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send_item(cau_pkg::MODE_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
        send_item(cau_pkg::MODE_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
        send_item(cau_pkg::MODE_MOD, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_MOD, 16'h0003, 16'h0004, 16'h7fff, 16'h7fff);
        send_item(cau_pkg::MODE_ARG, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'hff00, 16'h0000, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'h8000, 16'h0001, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'h8000, 16'hffff, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_ARG, 16'hfc00, 16'hfc00, 16'h0000, 16'h0000);
        send_item(cau_pkg::MODE_CONJ, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
        send_item(cau_pkg::MODE_CONJ, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
        send_item(3'd7, 16'h7fff, 16'h8000, 16'h1234, 16'hffff);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_item(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = cau_pkg::MODE_ADD;
        i_a_re       = '0;
        i_a_im       = '0;
        i_b_re       = '0;
        i_b_im       = '0;
        mismatch_cnt = 0;
        result_cnt   = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        foreach (mode_cnt[m]) mode_cnt[m] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(1000);
        idle_on = 1'b0;
        test_random(330);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d results: add %0d sub %0d mul %0d div %0d", result_cnt,
                 mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
        $display("modulus %0d argument %0d conjugate %0d unused %0d, mismatches %0d",
                 mode_cnt[4], mode_cnt[5], mode_cnt[6], mode_cnt[7], mismatch_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/cau_cordic.sv
rtl/complex_arithmetic_unit.sv
tb/tb_top.sv
